[hdl/rtlb_pkg.sv]
// Shared definitions for the right-triangle leg pipeline.
// Holds default widths, the base-sixty constants and the stage control struct.
// No dependencies.
package rtlb_pkg;

    localparam int LEG_BITS_DEF = 15;
    localparam int BASE_SIXTY   = 60;
    localparam int SIXTIES_W    = 10;
    localparam int UNITS_W      = 6;

    // Control bits that travel with each word through every stage.
    typedef struct packed {
        logic valid;
        logic invalid;
    } t_ctl;

endpackage

[hdl/rtlb_sqrt_stage.sv]
// One step of the digit-by-digit square root, registered.
// Depends on rtlb_pkg for the stage control struct.
module rtlb_sqrt_stage #(
    parameter int LEG_BITS = rtlb_pkg::LEG_BITS_DEF,
    parameter int STEP     = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  rtlb_pkg::t_ctl          i_ctl,
    input  logic [2*LEG_BITS-1:0]   i_rem,
    input  logic [2*LEG_BITS-1:0]   i_root,
    output rtlb_pkg::t_ctl          o_ctl,
    output logic [2*LEG_BITS-1:0]   o_rem,
    output logic [2*LEG_BITS-1:0]   o_root
);

    localparam int RW = 2 * LEG_BITS;
    localparam logic [RW-1:0] TRIAL = RW'(1) << (2 * STEP);

    rtlb_pkg::t_ctl  r_ctl;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW-1:0]   n_rem;
    logic [RW-1:0]   n_root;
    logic [RW:0]     w_sum;
    logic            w_fits;

    // The trial value fits when the remainder can absorb root plus trial.
    always_comb begin
        w_sum  = {1'b0, i_root} + {1'b0, TRIAL};
        w_fits = {1'b0, i_rem} >= w_sum;
        if (w_fits) begin
            n_rem  = i_rem - w_sum[RW-1:0];
            n_root = (i_root >> 1) + TRIAL;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

[hdl/rtlb_base60.sv]
// Splits the leg into sixties and units with a reciprocal multiply, two stages.
// Depends on rtlb_pkg for widths, the base constant and the control struct.
module rtlb_base60 #(
    parameter int LEG_BITS = rtlb_pkg::LEG_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  rtlb_pkg::t_ctl                   i_ctl,
    input  logic [LEG_BITS-1:0]              i_leg,
    output rtlb_pkg::t_ctl                   o_ctl,
    output logic [LEG_BITS-1:0]              o_leg,
    output logic [rtlb_pkg::SIXTIES_W-1:0]   o_sixties,
    output logic [rtlb_pkg::UNITS_W-1:0]     o_units
);

    localparam int UW    = rtlb_pkg::UNITS_W;
    localparam int SHIFT = LEG_BITS + 6;
    // Reciprocal of sixty rounded up; the error stays below 2^SHIFT over the leg range.
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / rtlb_pkg::BASE_SIXTY) + 64'd1;
    localparam int PW    = (2 * LEG_BITS + 1 > 16) ? 2 * LEG_BITS + 1 : 16;
    localparam logic [UW-1:0] BASE = UW'(rtlb_pkg::BASE_SIXTY);

    rtlb_pkg::t_ctl                   r_ctl_a;
    logic [LEG_BITS-1:0]              r_leg_a;
    logic [PW-1:0]                    r_prod;
    rtlb_pkg::t_ctl                   r_ctl_b;
    logic [LEG_BITS-1:0]              r_leg_b;
    logic [rtlb_pkg::SIXTIES_W-1:0]   r_sixties;
    logic [UW-1:0]                    r_units;
    logic [PW-1:0]                    w_quot;
    logic [UW-1:0]                    w_units;

    // The remainder is below sixty, so six bits of arithmetic are exact.
    always_comb begin
        w_quot  = r_prod >> SHIFT;
        w_units = UW'(r_leg_a) - UW'(UW'(w_quot) * BASE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_leg_a   <= i_leg;
            r_prod    <= PW'(i_leg) * PW'(RECIP);
            r_leg_b   <= r_leg_a;
            r_sixties <= w_quot[rtlb_pkg::SIXTIES_W-1:0];
            r_units   <= w_units;
        end
    end

    assign o_ctl     = r_ctl_b;
    assign o_leg     = r_leg_b;
    assign o_sixties = r_sixties;
    assign o_units   = r_units;

endmodule

[hdl/right_triangle_leg_base60.sv]
// Top level of the right-triangle missing-leg pipeline with a base-sixty split.
// Depends on rtlb_pkg, rtlb_sqrt_stage and rtlb_base60.
//
//  Channel   Dir  Handshake              Word contents (lowest bit first)
//  s         in   i_s_tvalid/o_s_tready  short_leg, hypotenuse
//  m         out  o_m_tvalid/i_m_tready  other_leg, sixties, units; tuser = invalid
//
// A word passes the stage with the squares, the stage with their difference, the
// square-root chain and the base-sixty split, in that order. One word can enter
// every cycle while the output slot is free.
// Reset clears only the control bits (valid and invalid) of the stages; data registers are not reset.
// When the output word is not taken, every stage holds, so nothing is lost or
// repeated; o_s_tready is low for exactly those cycles.
module right_triangle_leg_base60 #(
    parameter int LEG_BITS = rtlb_pkg::LEG_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // Fields from bit 0: short_leg, hypotenuse, zero padding.
    input  logic [((2*LEG_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // Fields from bit 0: other_leg, sixties, units, zero padding.
    output logic [((LEG_BITS+16+7)/8)*8-1:0] o_m_tdata,
    // Field: invalid (short leg longer than the hypotenuse).
    output logic                       o_m_tuser
);

    localparam int RW  = 2 * LEG_BITS;
    localparam int ODW = ((LEG_BITS + 16 + 7) / 8) * 8;
    localparam int OFW = LEG_BITS + rtlb_pkg::SIXTIES_W + rtlb_pkg::UNITS_W;

    // The whole pipeline advances together whenever the output slot is free.
    logic w_adv;

    logic [LEG_BITS-1:0]     w_a;
    logic [LEG_BITS-1:0]     w_c;

    // Stage one: squares and the validity check.
    rtlb_pkg::t_ctl          r_ctl_sq;
    logic [RW-1:0]           r_a_sq;
    logic [RW-1:0]           r_c_sq;

    // Stage two: the radicand, forced to zero for an invalid pair so the
    // results come out zero without any extra muxing at the end.
    rtlb_pkg::t_ctl          r_ctl_rad;
    logic [RW-1:0]           r_rad;

    rtlb_pkg::t_ctl          w_ctl_chain  [LEG_BITS+1];
    logic [RW-1:0]           w_rem_chain  [LEG_BITS+1];
    logic [RW-1:0]           w_root_chain [LEG_BITS+1];

    rtlb_pkg::t_ctl                   w_ctl_out;
    logic [LEG_BITS-1:0]              w_leg_out;
    logic [rtlb_pkg::SIXTIES_W-1:0]   w_sixties;
    logic [rtlb_pkg::UNITS_W-1:0]     w_units;

    assign w_adv      = !w_ctl_out.valid || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_a        = i_s_tdata[LEG_BITS-1:0];
    assign w_c        = i_s_tdata[2*LEG_BITS-1:LEG_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_sq  <= '0;
            r_ctl_rad <= '0;
        end else if (w_adv) begin
            r_ctl_sq.valid   <= i_s_tvalid;
            r_ctl_sq.invalid <= w_a > w_c;
            r_ctl_rad        <= r_ctl_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_sq <= RW'(w_a) * RW'(w_a);
            r_c_sq <= RW'(w_c) * RW'(w_c);
            r_rad  <= r_ctl_sq.invalid ? '0 : r_c_sq - r_a_sq;
        end
    end

    // Square-root chain: stage k tries root bit LEG_BITS-1-k. The first trial
    // power of four above the radicand range can never fit and is left out.
    assign w_ctl_chain[0]  = r_ctl_rad;
    assign w_rem_chain[0]  = r_rad;
    assign w_root_chain[0] = '0;

    for (genvar k = 0; k < LEG_BITS; k++) begin : g_sqrt
        rtlb_sqrt_stage #(
            .LEG_BITS (LEG_BITS),
            .STEP     (LEG_BITS - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl_chain[k]),
            .i_rem   (w_rem_chain[k]),
            .i_root  (w_root_chain[k]),
            .o_ctl   (w_ctl_chain[k+1]),
            .o_rem   (w_rem_chain[k+1]),
            .o_root  (w_root_chain[k+1])
        );
    end

    // The final remainder is not needed past the last root step.
    rtlb_base60 #(
        .LEG_BITS (LEG_BITS)
    ) u_base60 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_ctl     (w_ctl_chain[LEG_BITS]),
        .i_leg     (w_root_chain[LEG_BITS][LEG_BITS-1:0]),
        .o_ctl     (w_ctl_out),
        .o_leg     (w_leg_out),
        .o_sixties (w_sixties),
        .o_units   (w_units)
    );

    assign o_m_tvalid = w_ctl_out.valid;
    assign o_m_tuser  = w_ctl_out.invalid;
    assign o_m_tdata  = ODW'({w_units, w_sixties, w_leg_out});

    // An invalid pair yields all-zero result fields.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[OFW-1:0] == '0)
        else $error("invalid word carries nonzero result fields");

    // The units field is a true remainder of sixty.
    a_units_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> 32'(w_units) < 32'(rtlb_pkg::BASE_SIXTY))
        else $error("units field out of range");

    // Sixties and units rebuild the leg whenever the quotient is not truncated.
    a_split_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && LEG_BITS <= 15 |->
        64'(w_sixties) * 64'(rtlb_pkg::BASE_SIXTY) + 64'(w_units) == 64'(w_leg_out))
        else $error("base-sixty split does not match the leg");

    // A held output word blocks input and keeps the whole pipeline frozen.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(w_leg_out)
        && $stable(w_ctl_chain[LEG_BITS]))
        else $error("pipeline moved during an output stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule
